### hw/rtl/ofd_pkg.sv
package ofd_pkg;

  // Frame buffer geometry
  localparam int unsigned BUF_LEN = 16;
  localparam int unsigned IDX_W   = $clog2(BUF_LEN);

  // Frame marker bytes
  localparam logic [7:0] HDR_BYTE = 8'hFE;
  localparam logic [7:0] END_BYTE = 8'hAA;

  // Displacement accumulator width (Q.4 fixed point)
  localparam int unsigned ACC_W = 48;

  // |speed| * height product and its quotient by 17
  localparam int unsigned PROD_W = 32;
  localparam int unsigned QUOT_W = 28;

  typedef enum logic [0:0] {
    REQ_BYTE  = 1'b0,
    REQ_INTEG = 1'b1
  } req_e;

  typedef enum logic [2:0] {
    EV_STORED = 3'd0,
    EV_ACCEPT = 3'd1,
    EV_REJECT = 3'd2,
    EV_WRAP   = 3'd3,
    EV_INTEG  = 3'd4
  } event_e;

  typedef struct packed {
    req_e        req_type;
    logic [7:0]  rx_byte;
    logic [15:0] height_mm;
  } in_req_t;

  typedef struct packed {
    event_e                    event_res;
    logic signed [15:0]        speed_x;
    logic signed [15:0]        speed_y;
    logic [7:0]                quality;
    logic signed [ACC_W-1:0]   move_x;
    logic signed [ACC_W-1:0]   move_y;
  } out_res_t;

  // Latest accepted frame contents
  typedef struct packed {
    logic signed [15:0] speed_x;
    logic signed [15:0] speed_y;
    logic [7:0]         quality;
  } flow_info_t;

endpackage

### hw/rtl/optical_flow_frame_decoder.sv
// Optical-flow sensor frame decoder with displacement integrator.
//
// Input channel (in_valid_i / in_stall_o / in_req_i) carries either a
// received serial byte or an integrate request with the sensor height.
// Output channel (out_valid_o / out_stall_i / out_res_o) returns one result
// per request, in order: an event code, the latest accepted speeds and
// quality, and both displacement accumulators after the request.
//
// Throughput is one request per cycle while the result register is not held by
// out_stall_i. An accepted request registers |speed| * height, then the
// reciprocal multiply that divides by 17, and then rounding and the saturating
// accumulate are loaded into the result register.
//
// Reset clears the frame buffer, write index, speeds, quality and both
// accumulators; no request is in flight afterwards.
// The pipeline advances as a whole: while a result waits and out_stall_i is
// high, in_stall_o is high and every stage holds; requests are taken as long
// as the result register is empty or being drained.
module optical_flow_frame_decoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ofd_pkg::in_req_t    in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ofd_pkg::out_res_t   out_res_o
);

  logic                                adv, accept;
  logic                                s1_vld_q, s2_vld_q, out_vld_q;
  ofd_pkg::event_e                     evt, s1_evt_q, s2_evt_q;
  ofd_pkg::flow_info_t                 info_q, info_d, s1_info_q, s2_info_q;
  logic [ofd_pkg::QUOT_W-1:0]          quot_x, quot_y;
  logic [ofd_pkg::PROD_W-1:0]          prod_x, prod_y;
  logic                                neg_x, neg_y, upd;
  logic signed [ofd_pkg::ACC_W-1:0]    acc_x, acc_y;
  ofd_pkg::out_res_t                   out_res_q;

  // Global pipeline advance
  assign adv        = !(out_vld_q && out_stall_i);
  assign accept     = in_valid_i && adv;
  assign in_stall_o = !adv;

  ofd_frame u_frame (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .req_i    (in_req_i),
    .evt_o    (evt),
    .info_q_o (info_q),
    .info_d_o (info_d)
  );

  ofd_scale u_scale_x (
    .clk_i    (clk_i),
    .en_i     (adv),
    .speed_i  (info_q.speed_x),
    .height_i (in_req_i.height_mm),
    .quot_o   (quot_x),
    .prod_o   (prod_x),
    .neg_o    (neg_x)
  );

  ofd_scale u_scale_y (
    .clk_i    (clk_i),
    .en_i     (adv),
    .speed_i  (info_q.speed_y),
    .height_i (in_req_i.height_mm),
    .quot_o   (quot_y),
    .prod_o   (prod_y),
    .neg_o    (neg_y)
  );

  // Accumulate when an integrate request leaves stage 2
  assign upd = adv && s2_vld_q && (s2_evt_q == ofd_pkg::EV_INTEG);

  ofd_accum u_accum_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (upd),
    .quot_i  (quot_x),
    .prod_i  (prod_x),
    .neg_i   (neg_x),
    .acc_d_o (acc_x)
  );

  ofd_accum u_accum_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (upd),
    .quot_i  (quot_y),
    .prod_i  (prod_y),
    .neg_i   (neg_y),
    .acc_d_o (acc_y)
  );

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q  <= in_valid_i;
      s2_vld_q  <= s1_vld_q;
      out_vld_q <= s2_vld_q;
    end
  end

  // Event and frame info travel with the request
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_evt_q  <= evt;
      s1_info_q <= info_d;
      s2_evt_q  <= s1_evt_q;
      s2_info_q <= s1_info_q;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_res_q.event_res <= s2_evt_q;
      out_res_q.speed_x   <= s2_info_q.speed_x;
      out_res_q.speed_y   <= s2_info_q.speed_y;
      out_res_q.quality   <= s2_info_q.quality;
      out_res_q.move_x    <= acc_x;
      out_res_q.move_y    <= acc_y;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_res_o   = out_res_q;

endmodule

### hw/rtl/ofd_frame.sv
module ofd_frame (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  ofd_pkg::in_req_t    req_i,
  output ofd_pkg::event_e     evt_o,
  output ofd_pkg::flow_info_t info_q_o,
  output ofd_pkg::flow_info_t info_d_o
);

  logic [7:0]                 buf_q [ofd_pkg::BUF_LEN];
  logic [ofd_pkg::IDX_W-1:0]  wr_idx_q, wr_idx_d;
  ofd_pkg::flow_info_t        info_q, info_d;
  logic [7:0]                 view [8];
  logic                       is_byte, is_last, is_end, hdr_ok, sum_ok;
  logic [7:0]                 sum;

  assign is_byte = (req_i.req_type == ofd_pkg::REQ_BYTE);
  assign is_last = (wr_idx_q == ofd_pkg::IDX_W'(ofd_pkg::BUF_LEN - 1));
  assign is_end  = (req_i.rx_byte == ofd_pkg::END_BYTE);

  // Frame bytes 0..7 as seen after this byte is written
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      view[i] = (wr_idx_q == ofd_pkg::IDX_W'(i)) ? req_i.rx_byte : buf_q[i];
    end
  end

  assign sum    = view[2] + view[3] + view[4] + view[5];
  assign hdr_ok = (view[0] == ofd_pkg::HDR_BYTE);
  assign sum_ok = (sum == view[6]);

  // Event code, next index and next speeds and quality
  always_comb begin
    info_d   = info_q;
    wr_idx_d = wr_idx_q;
    evt_o    = ofd_pkg::EV_INTEG;
    if (is_byte) begin
      if (is_end) begin
        wr_idx_d = '0;
        if (hdr_ok && sum_ok) begin
          evt_o          = ofd_pkg::EV_ACCEPT;
          info_d.speed_x = {view[3], view[2]};
          info_d.speed_y = {view[5], view[4]};
          info_d.quality = view[7];
        end else begin
          evt_o = ofd_pkg::EV_REJECT;
        end
      end else if (is_last) begin
        wr_idx_d = '0;
        evt_o    = ofd_pkg::EV_WRAP;
      end else begin
        wr_idx_d = wr_idx_q + 1'b1;
        evt_o    = ofd_pkg::EV_STORED;
      end
    end
  end

  // Buffer write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ofd_pkg::BUF_LEN; i++) begin
        buf_q[i] <= '0;
      end
    end else if (accept_i && is_byte) begin
      buf_q[wr_idx_q] <= req_i.rx_byte;
    end
  end

  // Index and frame results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= '0;
      info_q   <= '0;
    end else if (accept_i) begin
      wr_idx_q <= wr_idx_d;
      info_q   <= info_d;
    end
  end

  assign info_q_o = info_q;
  assign info_d_o = info_d;

endmodule

### hw/rtl/ofd_scale.sv
module ofd_scale (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [15:0]           speed_i,
  input  logic [15:0]                  height_i,
  output logic [ofd_pkg::QUOT_W-1:0]   quot_o,
  output logic [ofd_pkg::PROD_W-1:0]   prod_o,
  output logic                         neg_o
);

  // ceil(2^36 / 17): exact floor division of any 32-bit value by 17
  localparam logic [31:0] RECIP17 = 32'hF0F0F0F1;
  localparam int unsigned RSHIFT  = 36;

  logic                         neg;
  logic [15:0]                  mag;
  logic [ofd_pkg::PROD_W-1:0]   prod1_q, prod2_q;
  logic                         neg1_q, neg2_q;
  logic [63:0]                  recip_full;
  logic [ofd_pkg::QUOT_W-1:0]   quot2_q;

  assign neg = speed_i[15];
  assign mag = neg ? (~speed_i + 16'd1) : speed_i;

  // Stage 1: |speed| * height
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod1_q <= {16'd0, mag} * {16'd0, height_i};
      neg1_q  <= neg;
    end
  end

  // Stage 2: quotient by 17 through the reciprocal
  assign recip_full = {32'd0, prod1_q} * {32'd0, RECIP17};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quot2_q <= recip_full[RSHIFT +: ofd_pkg::QUOT_W];
      prod2_q <= prod1_q;
      neg2_q  <= neg1_q;
    end
  end

  assign quot_o = quot2_q;
  assign prod_o = prod2_q;
  assign neg_o  = neg2_q;

endmodule

### hw/rtl/ofd_accum.sv
module ofd_accum (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                upd_i,
  input  logic [ofd_pkg::QUOT_W-1:0]          quot_i,
  input  logic [ofd_pkg::PROD_W-1:0]          prod_i,
  input  logic                                neg_i,
  output logic signed [ofd_pkg::ACC_W-1:0]    acc_d_o
);

  localparam int unsigned DQ_W  = ofd_pkg::QUOT_W + 4;
  localparam int unsigned SUM_W = ofd_pkg::ACC_W + 1;

  logic signed [ofd_pkg::ACC_W-1:0]  acc_q, acc_d;
  logic [4:0]                        rem;
  logic [3:0]                        frac;
  logic [DQ_W-1:0]                   mag;
  logic signed [DQ_W:0]              delta;
  logic signed [SUM_W-1:0]           sum;

  // Remainder of the product by 17, 0..16; only low bits matter
  assign rem  = prod_i[4:0] - ({quot_i[0], 4'd0} + quot_i[4:0]);

  // floor((16*rem + 8) / 17): rem up to 8 maps to itself, above it to rem-1
  assign frac = (rem > 5'd8) ? 4'(rem - 5'd1) : rem[3:0];

  // Rounded |speed| * height * 16 / 17, then signed
  assign mag   = {quot_i, frac};
  assign delta = neg_i ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  assign sum   = SUM_W'(acc_q) + SUM_W'(delta);

  // Saturating add
  always_comb begin
    acc_d = acc_q;
    if (upd_i) begin
      case (sum[SUM_W-1:SUM_W-2])
        2'b01:   acc_d = {1'b0, {(ofd_pkg::ACC_W-1){1'b1}}};
        2'b10:   acc_d = {1'b1, {(ofd_pkg::ACC_W-1){1'b0}}};
        default: acc_d = sum[ofd_pkg::ACC_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_d_o = acc_d;

endmodule
